// ===== sv/uyvy2rgb_pkg.sv =====
// Shared types and helper functions for the UYVY to RGB pixel-pair converter.
// Depends on nothing; the stage modules, the top level and the testbench import it.
package uyvy2rgb_pkg;

    localparam int unsigned ChanW = 8;
    localparam int unsigned TermW = 18;
    localparam int unsigned SumW  = TermW + 1;

    localparam logic [TermW-1:0] LumaGain   = TermW'(298);
    localparam logic [TermW-1:0] RoundBias  = TermW'(128);
    localparam logic [ChanW-1:0] ChannelMax = ChanW'(255);

    typedef logic [ChanW-1:0]        t_chan;
    typedef logic signed [TermW-1:0] t_term;
    typedef logic signed [SumW-1:0]  t_sum;

    // Raw pixel pair as it arrives on the input channel.
    typedef struct packed {
        t_chan chroma_blue;
        t_chan luma_first;
        t_chan chroma_red;
        t_chan luma_second;
        logic  frame_end;
    } t_pix_pair;

    // Stage 1: luma bases and chroma contributions, all scaled by 256.
    typedef struct packed {
        t_term base_first;
        t_term base_second;
        t_term red_term;
        t_term green_term;
        t_term blue_term;
        logic  frame_end;
    } t_terms;

    // Stage 2: full channel sums before shift and clamp.
    typedef struct packed {
        t_sum red_first;
        t_sum green_first;
        t_sum blue_first;
        t_sum red_second;
        t_sum green_second;
        t_sum blue_second;
        logic frame_end;
    } t_sums;

    // Stage 3: final RGB pair.
    typedef struct packed {
        t_chan red_first;
        t_chan green_first;
        t_chan blue_first;
        t_chan red_second;
        t_chan green_second;
        t_chan blue_second;
        logic  frame_end;
    } t_rgb_pair;

    // Offset-binary byte minus 128 is the byte with its top bit flipped.
    function automatic logic signed [ChanW-1:0] chroma_diff(input t_chan code);
        chroma_diff = {~code[ChanW-1], code[ChanW-2:0]};
    endfunction

    // Divide by 256 and limit to 0..255.
    function automatic t_chan clamp_channel(input t_sum sum);
        if (sum[SumW-1]) begin
            clamp_channel = '0;
        end else if (|sum[SumW-2:ChanW+8]) begin
            clamp_channel = ChannelMax;
        end else begin
            clamp_channel = sum[ChanW+7:8];
        end
    endfunction

endpackage

// ===== sv/uyvy2rgb_if.sv =====
// Valid/ready channel interfaces for the pixel-pair input and the RGB output.
// Depends on nothing; instantiated by the environment around the top level.
interface uyvy2rgb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chroma_blue;
    logic [7:0] luma_first;
    logic [7:0] chroma_red;
    logic [7:0] luma_second;
    logic       frame_end;

    modport source (
        output valid, chroma_blue, luma_first, chroma_red, luma_second, frame_end,
        input  ready
    );
    modport sink (
        input  valid, chroma_blue, luma_first, chroma_red, luma_second, frame_end,
        output ready
    );
endinterface

interface uyvy2rgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;

    modport source (
        output valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second, frame_end_out,
        input  ready
    );
    modport sink (
        input  valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second, frame_end_out,
        output ready
    );
endinterface

// ===== sv/uyvy2rgb_product.sv =====
// First pipeline stage: constant multiplications of luma and chroma.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_product
    import uyvy2rgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_pix_pair i_pair,
    output t_terms    o_terms
);

    logic signed [ChanW-1:0] du;
    logic signed [ChanW-1:0] dv;
    t_terms                  n_terms;
    t_terms                  r_terms;

    always_comb begin
        du = chroma_diff(i_pair.chroma_blue);
        dv = chroma_diff(i_pair.chroma_red);
        n_terms.base_first  = t_term'(TermW'(i_pair.luma_first) * LumaGain + RoundBias);
        n_terms.base_second = t_term'(TermW'(i_pair.luma_second) * LumaGain + RoundBias);
        n_terms.red_term    = t_term'(18'sd409 * dv);
        n_terms.green_term  = t_term'(18'sd0 - 18'sd100 * du - 18'sd208 * dv);
        n_terms.blue_term   = t_term'(18'sd516 * du);
        n_terms.frame_end   = i_pair.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ===== sv/uyvy2rgb_sum.sv =====
// Second pipeline stage: adds the luma base to each chroma contribution.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_sum
    import uyvy2rgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_terms i_terms,
    output t_sums  o_sums
);

    t_sums n_sums;
    t_sums r_sums;

    always_comb begin
        n_sums.red_first    = t_sum'(i_terms.base_first)  + t_sum'(i_terms.red_term);
        n_sums.green_first  = t_sum'(i_terms.base_first)  + t_sum'(i_terms.green_term);
        n_sums.blue_first   = t_sum'(i_terms.base_first)  + t_sum'(i_terms.blue_term);
        n_sums.red_second   = t_sum'(i_terms.base_second) + t_sum'(i_terms.red_term);
        n_sums.green_second = t_sum'(i_terms.base_second) + t_sum'(i_terms.green_term);
        n_sums.blue_second  = t_sum'(i_terms.base_second) + t_sum'(i_terms.blue_term);
        n_sums.frame_end    = i_terms.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

// ===== sv/uyvy2rgb_clamp.sv =====
// Third pipeline stage: shift by eight and saturate each channel to 0..255.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_clamp
    import uyvy2rgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_sums     i_sums,
    output t_rgb_pair o_rgb
);

    t_rgb_pair n_rgb;
    t_rgb_pair r_rgb;

    always_comb begin
        n_rgb.red_first    = clamp_channel(i_sums.red_first);
        n_rgb.green_first  = clamp_channel(i_sums.green_first);
        n_rgb.blue_first   = clamp_channel(i_sums.blue_first);
        n_rgb.red_second   = clamp_channel(i_sums.red_second);
        n_rgb.green_second = clamp_channel(i_sums.green_second);
        n_rgb.blue_second  = clamp_channel(i_sums.blue_second);
        n_rgb.frame_end    = i_sums.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

// ===== sv/uyvy_to_rgba_converter_unit.sv =====
// Path: an accepted input transaction moves through the product, sum and clamp
// registers to its output transaction. Throughput: one pixel pair per cycle;
// the three-stage pipeline takes a new transaction every cycle as long as the
// output side keeps taking results. Reset: synchronous, active low; it clears
// the stage valid bits only, so the pipeline comes out of reset empty and ready.
module uyvy_to_rgba_converter_unit
    import uyvy2rgb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    uyvy2rgb_pix_if.sink   i_pix,
    uyvy2rgb_rgb_if.source o_rgb
);

    localparam int unsigned NumStages = 3;

    // One valid bit per register stage, moving along with the payload.
    logic [NumStages-1:0] r_valid;
    logic [NumStages-1:0] n_valid;
    logic [NumStages-1:0] stage_en;

    t_pix_pair in_pair;
    t_terms    terms;
    t_sums     sums;
    t_rgb_pair rgb;

    // A stage may load when it is empty or when the stage after it loads in the
    // same cycle. Bubbles are squeezed out, and a stalled stage holds its data.
    always_comb begin
        stage_en[2] = !r_valid[2] || o_rgb.ready;
        stage_en[1] = !r_valid[1] || stage_en[2];
        stage_en[0] = !r_valid[0] || stage_en[1];
    end

    always_comb begin
        n_valid = r_valid;
        if (stage_en[0]) begin
            n_valid[0] = i_pix.valid;
        end
        if (stage_en[1]) begin
            n_valid[1] = r_valid[0];
        end
        if (stage_en[2]) begin
            n_valid[2] = r_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign i_pix.ready = stage_en[0];

    always_comb begin
        in_pair.chroma_blue = i_pix.chroma_blue;
        in_pair.luma_first  = i_pix.luma_first;
        in_pair.chroma_red  = i_pix.chroma_red;
        in_pair.luma_second = i_pix.luma_second;
        in_pair.frame_end   = i_pix.frame_end;
    end

    // Stage 1: luma times 298 plus rounding, and the three chroma products.
    uyvy2rgb_product u_product (
        .i_clk   (i_clk),
        .i_en    (stage_en[0]),
        .i_pair  (in_pair),
        .o_terms (terms)
    );

    // Stage 2: the six channel sums, sharing chroma terms across the pair.
    uyvy2rgb_sum u_sum (
        .i_clk   (i_clk),
        .i_en    (stage_en[1]),
        .i_terms (terms),
        .o_sums  (sums)
    );

    // Stage 3: divide by 256 and saturate; this is also the output register.
    uyvy2rgb_clamp u_clamp (
        .i_clk  (i_clk),
        .i_en   (stage_en[2]),
        .i_sums (sums),
        .o_rgb  (rgb)
    );

    assign o_rgb.valid         = r_valid[2];
    assign o_rgb.red_first     = rgb.red_first;
    assign o_rgb.green_first   = rgb.green_first;
    assign o_rgb.blue_first    = rgb.blue_first;
    assign o_rgb.red_second    = rgb.red_second;
    assign o_rgb.green_second  = rgb.green_second;
    assign o_rgb.blue_second   = rgb.blue_second;
    assign o_rgb.frame_end_out = rgb.frame_end;

`ifndef NO_ASSERTIONS
    // The pipeline is empty in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_valid == '0)
        else $error("pipeline not empty after reset");

    // An accepted input transaction always lands in the first stage.
    a_input_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_valid[0])
        else $error("accepted transaction lost at stage 1");

    // A stalled middle stage keeps its valid data and sums.
    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && !stage_en[1] |=> r_valid[1] && $stable(sums))
        else $error("stalled stage 2 lost or changed its data");

    // The stage in front of a held output never advances into it.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] && !o_rgb.ready |=> r_valid[2] && $stable(rgb))
        else $error("output register overwritten while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the UYVY to RGB pixel-pair converter.
// Depends on uyvy2rgb_pkg and the two valid/ready channel interfaces;
// every output transaction is compared with a typed-in result or a local integer predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uyvy2rgb_pkg::*;

    // Conversion constants of BT.601 in 8.8 fixed point, luma left unoffset.
    localparam int ChromaOffset = 128;
    localparam int RoundBias    = 128;
    localparam int LumaCoef     = 298;
    localparam int RedFromV     = 409;
    localparam int GreenFromU   = 100;
    localparam int GreenFromV   = 208;
    localparam int BlueFromU    = 516;
    localparam int ChanTop      = 255;

    // The tail wait after the last result outlasts the pass through the product,
    // sum and clamp registers, so a stray extra transaction still gets caught.
    localparam int TailCycles   = 12;
    // The limit is set for about 1500 pairs under heavy idling on both sides.
    localparam int CycleLimit   = 200_000;
    localparam int NumPhases    = 4;

    logic clk;
    logic rst_n;

    uyvy2rgb_pix_if pix_ch ();
    uyvy2rgb_rgb_if rgb_ch ();

    uyvy_to_rgba_converter_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch),
        .o_rgb   (rgb_ch)
    );

    // One row of the directed table. Where the result is obvious (neutral
    // chroma at black or at full luma) it is typed in; other rows go through
    // the predictor.
    typedef struct {
        t_pix_pair stim;
        bit        typed;
        t_rgb_pair result;
    } t_directed_row;

    t_rgb_pair     pending_rgb[$];
    t_directed_row directed_rows[$];

    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;
    int          error_count;
    int          pairs_sent;
    int          pairs_checked;
    int          frame_ends_sent;
    int          directed_count;
    int          watchdog_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Flooring shift by 8 followed by the clamp to one byte.
    function automatic t_chan saturate_scaled(input int total);
        if (total < 0) begin
            return '0;
        end
        if ((total >>> 8) > ChanTop) begin
            return t_chan'(ChanTop);
        end
        return t_chan'(total >>> 8);
    endfunction

    // Predicts both pixels of one pair. The chroma differences are shared,
    // each pixel has its own luma base.
    function automatic t_rgb_pair predict_rgb_pair(input t_pix_pair p);
        int        du;
        int        dv;
        int        base_a;
        int        base_b;
        t_rgb_pair r;
        du     = int'(p.chroma_blue) - ChromaOffset;
        dv     = int'(p.chroma_red) - ChromaOffset;
        base_a = LumaCoef * int'(p.luma_first) + RoundBias;
        base_b = LumaCoef * int'(p.luma_second) + RoundBias;
        r.red_first    = saturate_scaled(base_a + RedFromV * dv);
        r.green_first  = saturate_scaled(base_a - GreenFromU * du - GreenFromV * dv);
        r.blue_first   = saturate_scaled(base_a + BlueFromU * du);
        r.red_second   = saturate_scaled(base_b + RedFromV * dv);
        r.green_second = saturate_scaled(base_b - GreenFromU * du - GreenFromV * dv);
        r.blue_second  = saturate_scaled(base_b + BlueFromU * du);
        r.frame_end    = p.frame_end;
        return r;
    endfunction

    // Random bytes lean on the corners where the clamps and the chroma
    // midpoint live, the rest is uniform.
    function automatic t_chan pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return t_chan'($urandom_range(129, 127));
            default: return t_chan'($urandom_range(255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s (result %0d): got %0d, expected %0d",
                 $realtime, what, pairs_checked, got, want);
        error_count++;
    endtask

    task automatic check_rgb_pair(input t_rgb_pair got, input t_rgb_pair want);
        if (got.red_first != want.red_first)
            report_mismatch("red_first", int'(got.red_first), int'(want.red_first));
        if (got.green_first != want.green_first)
            report_mismatch("green_first", int'(got.green_first), int'(want.green_first));
        if (got.blue_first != want.blue_first)
            report_mismatch("blue_first", int'(got.blue_first), int'(want.blue_first));
        if (got.red_second != want.red_second)
            report_mismatch("red_second", int'(got.red_second), int'(want.red_second));
        if (got.green_second != want.green_second)
            report_mismatch("green_second", int'(got.green_second),
                            int'(want.green_second));
        if (got.blue_second != want.blue_second)
            report_mismatch("blue_second", int'(got.blue_second), int'(want.blue_second));
        if (got.frame_end != want.frame_end)
            report_mismatch("frame_end_out", int'(got.frame_end), int'(want.frame_end));
    endtask

    // Offers one pair on the input channel, after a random number of idle
    // cycles, and records its expected result once the transaction is taken.
    // The payload carries junk while valid is low.
    task automatic send_pair(input t_pix_pair stim, input t_rgb_pair want);
        while ($urandom_range(99) < sender_idle_pct) begin
            pix_ch.valid       <= 1'b0;
            pix_ch.chroma_blue <= t_chan'($urandom);
            pix_ch.luma_first  <= t_chan'($urandom);
            pix_ch.chroma_red  <= t_chan'($urandom);
            pix_ch.luma_second <= t_chan'($urandom);
            pix_ch.frame_end   <= 1'($urandom);
            @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.chroma_blue <= stim.chroma_blue;
        pix_ch.luma_first  <= stim.luma_first;
        pix_ch.chroma_red  <= stim.chroma_red;
        pix_ch.luma_second <= stim.luma_second;
        pix_ch.frame_end   <= stim.frame_end;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        pending_rgb.push_back(want);
        pairs_sent++;
        if (stim.frame_end) frame_ends_sent++;
    endtask

    // Stops offering input and waits until every expected result is out.
    task automatic drain_pipeline();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0) @(posedge clk);
    endtask

    // Output side: each rising edge first checks a completed transaction,
    // then picks the ready level for the next cycle. Values read right after
    // the edge are the ones the block sampled there.
    initial begin
        t_rgb_pair got;
        rgb_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rgb_ch.valid && rgb_ch.ready) begin
                got.red_first    = rgb_ch.red_first;
                got.green_first  = rgb_ch.green_first;
                got.blue_first   = rgb_ch.blue_first;
                got.red_second   = rgb_ch.red_second;
                got.green_second = rgb_ch.green_second;
                got.blue_second  = rgb_ch.blue_second;
                got.frame_end    = rgb_ch.frame_end_out;
                if (pending_rgb.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    check_rgb_pair(got, pending_rgb.pop_front());
                end
                pairs_checked++;
            end
            rgb_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: the run must end well inside the cycle limit.
    initial begin
        for (watchdog_cycles = 0; watchdog_cycles < CycleLimit; watchdog_cycles++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 watchdog_cycles, pending_rgb.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        t_pix_pair   stim;
        t_rgb_pair   want;
        int unsigned phase_idle[NumPhases];
        int unsigned phase_stall[NumPhases];
        int          frame_len;

        // Phases: free flow, sender idling, receiver stalling, both.
        phase_idle  = '{0, 62, 0, 27};
        phase_stall = '{0, 0, 62, 27};

        sender_idle_pct    = 0;
        sink_stall_pct     = 0;
        error_count        = 0;
        pairs_sent         = 0;
        pairs_checked      = 0;
        frame_ends_sent    = 0;
        rst_n              <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.chroma_blue <= '0;
        pix_ch.luma_first  <= '0;
        pix_ch.chroma_red  <= '0;
        pix_ch.luma_second <= '0;
        pix_ch.frame_end   <= 1'b0;

        // Neutral chroma at black and at saturated white, then the negative
        // and oversized sums from both chroma extremes, then mixed patterns.
        directed_rows.push_back('{'{8'd128, 8'd0, 8'd128, 8'd0, 1'b0}, 1'b1,
                                  '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}});
        directed_rows.push_back('{'{8'd128, 8'd255, 8'd128, 8'd255, 1'b1}, 1'b1,
                                  '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}});
        directed_rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0,
                                  '{default: '0}});
        directed_rows.push_back('{'{8'd0, 8'd0, 8'd255, 8'd255, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd255, 8'd255, 8'd0, 8'd0, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd128, 8'd1, 8'd128, 8'd254, 1'b0}, 1'b0,
                                  '{default: '0}});
        directed_rows.push_back('{'{8'd127, 8'd128, 8'd129, 8'd127, 1'b0}, 1'b0,
                                  '{default: '0}});
        directed_rows.push_back('{'{8'd0, 8'd255, 8'd128, 8'd0, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd255, 8'd0, 8'd128, 8'd128, 1'b1}, 1'b0,
                                  '{default: '0}});
        directed_rows.push_back('{'{8'd128, 8'd200, 8'd0, 8'd50, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd128, 8'd50, 8'd255, 8'd200, 1'b0}, 1'b0,
                                  '{default: '0}});
        directed_rows.push_back('{'{8'haa, 8'h55, 8'h55, 8'haa, 1'b1}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'h55, 8'haa, 8'haa, 8'h55, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd1, 8'd16, 8'd254, 8'd235, 1'b0}, 1'b0, '{default: '0}});
        directed_rows.push_back('{'{8'd254, 8'd235, 8'd1, 8'd16, 1'b1}, 1'b0, '{default: '0}});
        directed_count = directed_rows.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed rows go back to back so the pipeline fills completely.
        foreach (directed_rows[i]) begin
            stim = directed_rows[i].stim;
            want = directed_rows[i].typed ? directed_rows[i].result : predict_rgb_pair(stim);
            send_pair(stim, want);
        end
        drain_pipeline();

        // Random pairs grouped into short frames, one flow-control setting
        // per phase. The input stays idle between phases until the pipeline
        // has emptied.
        frame_len = 0;
        for (int ph = 0; ph < NumPhases; ph++) begin
            sender_idle_pct = phase_idle[ph];
            sink_stall_pct  = phase_stall[ph];
            for (int n = 0; n < 375; n++) begin
                if (frame_len == 0) frame_len = $urandom_range(24, 1);
                frame_len--;
                stim.chroma_blue = pick_byte();
                stim.luma_first  = pick_byte();
                stim.chroma_red  = pick_byte();
                stim.luma_second = pick_byte();
                stim.frame_end   = (frame_len == 0);
                send_pair(stim, predict_rgb_pair(stim));
            end
            drain_pipeline();
        end

        repeat (TailCycles) @(posedge clk);

        $display("Sent %0d pixel pairs (%0d directed) with %0d frame ends, checked %0d results,",
                 pairs_sent, directed_count, frame_ends_sent, pairs_checked);
        $display("over free flow, input idling, output stalling and both; %0d mismatches.",
                 error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/uyvy2rgb_pkg.sv
sv/uyvy2rgb_if.sv
sv/uyvy2rgb_product.sv
sv/uyvy2rgb_sum.sv
sv/uyvy2rgb_clamp.sv
sv/uyvy_to_rgba_converter_unit.sv
tb/tb.sv
